// ===== src/prelu_channel_activation_top_assert.svh =====
// Assertion macros shared by the PReLU block.
`ifndef PRELU_CHANNEL_ACTIVATION_TOP_ASSERT_SVH
`define PRELU_CHANNEL_ACTIVATION_TOP_ASSERT_SVH

// Check that the consequence holds in the same cycle as the trigger.
`define PCA_ASSERT_NOW(label, clk, rst, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Check that the consequence holds in the cycle after the trigger.
`define PCA_ASSERT_NEXT(label, clk, rst, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// ===== src/pca_pkg.sv =====
package pca_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int SLOPE_W      = 16;
  localparam int SLOPE_FRAC   = 12;
  localparam int CHAN_W       = 6;
  localparam int MAX_CHANNELS = 64;
  localparam int POS_W        = 20;
  localparam int MODE_W       = 2;
  localparam int CCOUNT_W     = 7;
  localparam int ICOUNT_W     = 21;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 21;
  localparam int PROD_W       = SAMPLE_W + SLOPE_W;

  localparam logic [CCOUNT_W-1:0] MAX_CHAN_CNT  = CCOUNT_W'(MAX_CHANNELS);
  localparam logic [ICOUNT_W-1:0] MAX_INNER_CNT = ICOUNT_W'(1 << POS_W);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CCOUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ICOUNT = 2'd2;

  // Slope source codes
  localparam logic [MODE_W-1:0] MODE_ALL     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CHANNEL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ELEMENT = 2'd2;

  // Item kinds
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  typedef struct packed {
    logic                       action;
    logic [CHAN_W-1:0]          slope_index;
    logic signed [SLOPE_W-1:0]  slope_value;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SLOPE_W-1:0]  element_slope;
    logic                       first;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_value;
    logic                       saturated;
    logic [CHAN_W-1:0]          channel;
  } result_t;

endpackage

// ===== src/pca_scale.sv =====
// Pass positive samples, scale the rest by the slope with floor and clamp.
module pca_scale (
  input  logic signed [pca_pkg::SAMPLE_W-1:0] sample,
  input  logic signed [pca_pkg::SLOPE_W-1:0]  slope,
  output logic signed [pca_pkg::SAMPLE_W-1:0] value,
  output logic                                saturated
);

  localparam int SHIFT_W = pca_pkg::PROD_W - pca_pkg::SLOPE_FRAC;
  localparam logic signed [SHIFT_W-1:0] SMAX =
    SHIFT_W'((1 << (pca_pkg::SAMPLE_W - 1)) - 1);
  localparam logic signed [SHIFT_W-1:0] SMIN = -SMAX - SHIFT_W'(1);

  logic signed [pca_pkg::PROD_W-1:0] product;
  logic signed [SHIFT_W-1:0]         scaled;

  // Dropping the low fraction bits of a two's complement value floors it.
  assign product = sample * slope;
  assign scaled  = product[pca_pkg::PROD_W-1:pca_pkg::SLOPE_FRAC];

  always_comb begin
    saturated = 1'b0;
    if (sample > 0) begin
      value = sample;
    end else if (scaled > SMAX) begin
      value     = SMAX[pca_pkg::SAMPLE_W-1:0];
      saturated = 1'b1;
    end else if (scaled < SMIN) begin
      value     = SMIN[pca_pkg::SAMPLE_W-1:0];
      saturated = 1'b1;
    end else begin
      value = scaled[pca_pkg::SAMPLE_W-1:0];
    end
  end

endmodule

// ===== src/prelu_channel_activation_top.sv =====
// Streaming PReLU. Each accepted sample word yields one result word, and one
// word is accepted every cycle while the result side keeps up; the result
// path is the slope memory's single registered read port, read at the edge
// that accepts the sample, followed by one multiply stage into the result
// register. Load words write the 64-entry slope memory in the cycle they
// are accepted and produce no result; a sample right after a load sees the
// new slope. Read of a never-written entry gives an unspecified slope. The
// user must write the configuration registers only while the block is
// idle; the block itself does not enforce this.
`include "prelu_channel_activation_top_assert.svh"

module prelu_channel_activation_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  pca_pkg::item_t                      item,
  output logic                                result_valid,
  input  logic                                result_ready,
  output pca_pkg::result_t                    result,
  input  logic                                cfg_write,
  input  logic [pca_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pca_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Configuration registers
  logic [pca_pkg::MODE_W-1:0]   slope_mode;
  logic [pca_pkg::CCOUNT_W-1:0] channel_count;
  logic [pca_pkg::ICOUNT_W-1:0] inner_count;

  // Position counters
  logic [pca_pkg::POS_W-1:0]    inner_position, inner_position_next;
  logic [pca_pkg::CHAN_W-1:0]   channel_index, channel_index_next;

  // Slope memory
  logic [pca_pkg::SLOPE_W-1:0]  slope_mem [pca_pkg::MAX_CHANNELS];
  logic [pca_pkg::SLOPE_W-1:0]  slope_rd;
  logic [pca_pkg::CHAN_W-1:0]   rd_addr;

  // Stage 1: accepted sample waiting on the multiply
  logic                                s1_valid;
  logic signed [pca_pkg::SAMPLE_W-1:0] s1_sample;
  logic signed [pca_pkg::SLOPE_W-1:0]  s1_eslope;
  logic                                s1_elem;
  logic [pca_pkg::CHAN_W-1:0]          s1_channel;

  logic item_fire, sample_fire, load_fire, s1_move, res_take;
  logic [pca_pkg::CCOUNT_W-1:0] eff_chan;
  logic [pca_pkg::ICOUNT_W-1:0] eff_inner;
  logic [pca_pkg::POS_W-1:0]    pos_base;
  logic [pca_pkg::ICOUNT_W-1:0] pos_inc;
  logic [pca_pkg::CCOUNT_W-1:0] ch_inc;
  logic [pca_pkg::CHAN_W-1:0]   ch_raw, ch_use;
  logic                         plane_done;

  logic signed [pca_pkg::SLOPE_W-1:0]  slope_sel;
  logic signed [pca_pkg::SAMPLE_W-1:0] scaled_value;
  logic                                scaled_sat;

  // Handshake: the result register frees when taken, stage 1 moves into it.
  assign res_take    = !result_valid || result_ready;
  assign s1_move     = s1_valid && res_take;
  assign item_ready  = !s1_valid || res_take;
  assign item_fire   = item_valid && item_ready;
  assign sample_fire = item_fire && (item.action == pca_pkg::ACT_SAMPLE);
  assign load_fire   = item_fire && (item.action == pca_pkg::ACT_LOAD);

  // Clamp counts: zero acts as one, oversized acts as the maximum.
  always_comb begin
    if (channel_count == '0) eff_chan = pca_pkg::CCOUNT_W'(1);
    else if (channel_count > pca_pkg::MAX_CHAN_CNT) eff_chan = pca_pkg::MAX_CHAN_CNT;
    else eff_chan = channel_count;

    if (inner_count == '0) eff_inner = pca_pkg::ICOUNT_W'(1);
    else if (inner_count > pca_pkg::MAX_INNER_CNT) eff_inner = pca_pkg::MAX_INNER_CNT;
    else eff_inner = inner_count;
  end

  // Channel attribution and counter advance for the incoming sample.
  always_comb begin
    pos_base = item.first ? '0 : inner_position;
    ch_raw   = item.first ? '0 : channel_index;
    ch_use   = ({1'b0, ch_raw} >= eff_chan) ? '0 : ch_raw;

    pos_inc    = {1'b0, pos_base} + pca_pkg::ICOUNT_W'(1);
    plane_done = (pos_inc >= eff_inner);
    ch_inc     = {1'b0, ch_use} + pca_pkg::CCOUNT_W'(1);

    if (plane_done) begin
      inner_position_next = '0;
      channel_index_next  = (ch_inc >= eff_chan) ? '0 : ch_inc[pca_pkg::CHAN_W-1:0];
    end else begin
      inner_position_next = pos_inc[pca_pkg::POS_W-1:0];
      channel_index_next  = ch_use;
    end

    // All mode reads entry zero; element mode ignores the read.
    rd_addr = (slope_mode == pca_pkg::MODE_CHANNEL) ? ch_use : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slope_mode    <= pca_pkg::MODE_ALL;
      channel_count <= pca_pkg::CCOUNT_W'(1);
      inner_count   <= pca_pkg::ICOUNT_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        pca_pkg::REG_MODE:   slope_mode    <= cfg_data[pca_pkg::MODE_W-1:0];
        pca_pkg::REG_CCOUNT: channel_count <= cfg_data[pca_pkg::CCOUNT_W-1:0];
        pca_pkg::REG_ICOUNT: inner_count   <= cfg_data[pca_pkg::ICOUNT_W-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Advance the counters on samples only; loads leave them alone.
  always_ff @(posedge clk) begin
    if (rst) begin
      inner_position <= '0;
      channel_index  <= '0;
    end else if (sample_fire) begin
      inner_position <= inner_position_next;
      channel_index  <= channel_index_next;
    end
  end

  // Write on a load word, registered read on a sample word.
  always_ff @(posedge clk) begin
    if (load_fire) begin
      slope_mem[item.slope_index] <= item.slope_value;
    end else if (sample_fire) begin
      slope_rd <= slope_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_fire) begin
      s1_valid <= (item.action == pca_pkg::ACT_SAMPLE);
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_fire) begin
      s1_sample  <= item.sample;
      s1_eslope  <= item.element_slope;
      s1_elem    <= (slope_mode != pca_pkg::MODE_ALL) && (slope_mode != pca_pkg::MODE_CHANNEL);
      s1_channel <= ch_use;
    end
  end

  assign slope_sel = s1_elem ? s1_eslope : slope_rd;

  pca_scale u_scale (
    .sample    (s1_sample),
    .slope     (slope_sel),
    .value     (scaled_value),
    .saturated (scaled_sat)
  );

  // Result register: hold until taken, load from stage 1 when it moves.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_take) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      result.out_value <= scaled_value;
      result.saturated <= scaled_sat;
      result.channel   <= s1_channel;
    end
  end

  // A first sample always lands on channel zero.
  `PCA_ASSERT_NEXT(a_first_chan0, clk, rst, sample_fire && item.first, s1_channel == '0)
  // A load word never occupies stage 1.
  `PCA_ASSERT_NEXT(a_load_no_s1, clk, rst, load_fire, !s1_valid)
  // A stalled stage 1 keeps its sample.
  `PCA_ASSERT_NEXT(a_s1_hold, clk, rst, s1_valid && !s1_move, s1_valid && $stable(s1_sample))
  // Saturation only ever reports a clamp bound.
  `PCA_ASSERT_NOW(a_sat_bound, clk, rst, result_valid && result.saturated,
    (result.out_value == 16'sh7fff) || (result.out_value == -16'sh8000))

endmodule
